/* rtl/core/rkc_pkg.sv */
package rkc_pkg;

  localparam int PIX_W = 8;
  localparam int CH_N = 3;
  localparam int COEF_W = 16;
  localparam int PROD_W = PIX_W + COEF_W + 1;
  localparam int HEIGHT_CAP = 1024;

  localparam logic [1:0] OP_COEF  = 2'd0;
  localparam logic [1:0] OP_PIX   = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_WIDTH = 2'd2;

  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd800;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd800;
  localparam logic [2:0]  RST_KERNEL_WIDTH = 3'd3;

  // Index 2 is red, 1 is green, 0 is blue.
  typedef logic [CH_N-1:0][PIX_W-1:0] rgb_t;

  typedef struct packed {
    logic shift;
    logic prod;
    logic csum;
  } cell_en_t;

endpackage

/* rtl/core/rkc_ram.sv */
module rkc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/rkc_cell.sv */
module rkc_cell #(
  parameter int NC = 5,
  parameter int CSUM_W = 28
) (
  input  logic                                   clk,
  input  rkc_pkg::cell_en_t                      en,
  input  rkc_pkg::rgb_t [NC-1:0]                 col_in,
  input  logic [NC-1:0][rkc_pkg::COEF_W-1:0]     coef,
  input  logic                                   col_ok,
  input  logic [NC-1:0]                          row_ok,
  output rkc_pkg::rgb_t [NC-1:0]                 col_out,
  output logic [rkc_pkg::CH_N-1:0][CSUM_W-1:0]   csum_r
);

  rkc_pkg::rgb_t [NC-1:0] col_r;
  logic signed [rkc_pkg::PROD_W-1:0] prod_r [rkc_pkg::CH_N][NC];
  logic [rkc_pkg::CH_N-1:0][CSUM_W-1:0] csum_nxt;

  assign col_out = col_r;

  always_comb begin
    for (int ch = 0; ch < rkc_pkg::CH_N; ch++) begin
      csum_nxt[ch] = '0;
      for (int b = 0; b < NC; b++) begin
        csum_nxt[ch] = csum_nxt[ch] + CSUM_W'($signed(prod_r[ch][b]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.shift) begin
      col_r <= col_in;
    end
    if (en.prod) begin
      for (int ch = 0; ch < rkc_pkg::CH_N; ch++) begin
        for (int b = 0; b < NC; b++) begin
          if (col_ok && row_ok[b]) begin
            prod_r[ch][b] <= $signed({1'b0, col_r[b][ch]}) * $signed(coef[b]);
          end else begin
            prod_r[ch][b] <= '0;
          end
        end
      end
    end
    if (en.csum) begin
      csum_r <= csum_nxt;
    end
  end

endmodule

/* rtl/core/rgb_kernel_convolution_top.sv */
// Channel   Handshake              Payload
// config    psel/penable/pready    paddr, pwdata, prdata
// input     in_valid/in_ready      in_op, in_coef_index, in_coef_value, in_red/green/blue
// output    out_valid/out_ready    out_red, out_green, out_blue, out_frame_end
//
// One request is taken per clock while out_ready does not stall the pipeline.
// The line buffer memory is read and written once per request, so it sustains one per clock.
// Reset clears counters and pipeline valids and reloads config registers; no clearing pass.
// in_ready follows the pipeline stage valids back from out_ready.
module rgb_kernel_convolution_top #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [4:0]  in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_end
);

  localparam int MAXR = (MAX_KERNEL - 1) / 2;
  localparam int NC = 2 * MAXR + 1;
  localparam int LR = 2 * MAXR;
  localparam int SLOTS = MAX_KERNEL * MAX_KERNEL;
  localparam int CIW = $clog2(SLOTS);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAXR + 1);
  localparam int SW = WW + 12;
  localparam int LW = rkc_pkg::CH_N * rkc_pkg::PIX_W * LR;
  localparam int CSUM_W = rkc_pkg::PROD_W + $clog2(NC);
  localparam int TS = CSUM_W + $clog2(NC);
  localparam int TS1 = TS + 1;

  logic [10:0] fw_r, fh_r;
  logic [2:0]  kw_r;
  logic [WW-1:0] w_eff;
  logic [10:0] h_eff;
  logic [RW-1:0] r_eff;
  logic [SW-1:0] lat;
  logic [2:0] kodd;

  logic cfg_wr;
  logic [1:0] cfg_idx;

  logic [AW-1:0] col_r, col_nxt, ox_r, ox_nxt;
  logic [11:0] row_r, row_nxt;
  logic [10:0] oy_r, oy_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  logic acc, adv, produce, last, in_frame;
  logic en0, en1, en2, en3, en4;
  logic v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic fe0_r, fe1_r, fe2_r, fe3_r, out_fe_r;
  logic [NC-1:0] cmask_nxt, rmask_nxt, cmask0_r, rmask0_r;

  logic [rkc_pkg::COEF_W-1:0] coef_mem [SLOTS];
  logic [NC-1:0][NC-1:0][rkc_pkg::COEF_W-1:0] coef_sel;

  logic [LW-1:0] ram_rdata, byp_data_r, wdata;
  logic byp_r;
  rkc_pkg::rgb_t [LR-1:0] line_word;
  rkc_pkg::rgb_t [NC-1:0] col_new;
  rkc_pkg::rgb_t [NC-1:0] col_chain [NC+1];
  logic [rkc_pkg::CH_N-1:0][CSUM_W-1:0] csum [NC];
  logic signed [TS-1:0] tsum_r [rkc_pkg::CH_N];
  rkc_pkg::rgb_t out_rgb_r;
  rkc_pkg::cell_en_t cen;

  function automatic logic [7:0] rnd_sat(input logic signed [TS-1:0] a);
    logic [TS1-1:0] u;
    u = ({1'b0, a} + (TS1'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    if (a[TS-1]) begin
      return 8'd0;
    end
    if (u > TS1'(255)) begin
      return 8'hFF;
    end
    return u[7:0];
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      rkc_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, fw_r};
      rkc_pkg::REG_FRAME_HEIGHT: prdata = {21'd0, fh_r};
      rkc_pkg::REG_KERNEL_WIDTH: prdata = {29'd0, kw_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= rkc_pkg::RST_FRAME_WIDTH;
      fh_r <= rkc_pkg::RST_FRAME_HEIGHT;
      kw_r <= rkc_pkg::RST_KERNEL_WIDTH;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rkc_pkg::REG_FRAME_WIDTH:  fw_r <= pwdata[10:0];
        rkc_pkg::REG_FRAME_HEIGHT: fh_r <= pwdata[10:0];
        rkc_pkg::REG_KERNEL_WIDTH: kw_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    if (fh_r == '0) begin
      h_eff = 11'd1;
    end else if (32'(fh_r) > 32'(rkc_pkg::HEIGHT_CAP)) begin
      h_eff = 11'(rkc_pkg::HEIGHT_CAP);
    end else begin
      h_eff = fh_r;
    end
    kodd = kw_r | 3'd1;
    if (32'(kodd >> 1) > 32'(MAXR)) begin
      r_eff = RW'(MAXR);
    end else begin
      r_eff = RW'(kodd >> 1);
    end
    lat = SW'(r_eff) * (SW'(w_eff) + SW'(1));
  end

  // Pipeline flow control
  assign en4 = !out_valid_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_ready = en0;

  assign acc = in_valid && in_ready;
  assign in_frame = row_r < 12'(h_eff);
  assign adv = acc && (in_op == rkc_pkg::OP_PIX || in_op == rkc_pkg::OP_FLUSH) &&
               !(in_frame && in_op == rkc_pkg::OP_FLUSH);
  assign produce = adv && (slot_r >= lat);
  assign last = (WW'(ox_r) + WW'(1) == w_eff) && (oy_r + 11'd1 == h_eff);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    slot_nxt = slot_r;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    if (adv) begin
      slot_nxt = slot_r + SW'(1);
      if (WW'(col_r) + WW'(1) == w_eff) begin
        col_nxt = '0;
        row_nxt = row_r + 12'd1;
      end else begin
        col_nxt = col_r + AW'(1);
      end
      if (produce) begin
        if (WW'(ox_r) + WW'(1) == w_eff) begin
          ox_nxt = '0;
          oy_nxt = oy_r + 11'd1;
        end else begin
          ox_nxt = ox_r + AW'(1);
        end
        if (last) begin
          col_nxt = '0;
          row_nxt = '0;
          slot_nxt = '0;
          ox_nxt = '0;
          oy_nxt = '0;
        end
      end
    end
    if (cfg_wr && (cfg_idx == rkc_pkg::REG_FRAME_WIDTH ||
                   cfg_idx == rkc_pkg::REG_FRAME_HEIGHT ||
                   cfg_idx == rkc_pkg::REG_KERNEL_WIDTH)) begin
      col_nxt = '0;
      row_nxt = '0;
      slot_nxt = '0;
      ox_nxt = '0;
      oy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      slot_r <= '0;
      ox_r <= '0;
      oy_r <= '0;
      byp_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      slot_r <= slot_nxt;
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      byp_r <= adv && (col_r == col_nxt);
    end
  end

  // Coefficient store
  always_ff @(posedge clk) begin
    if (acc && in_op == rkc_pkg::OP_COEF && 32'(in_coef_index) < 32'(SLOTS)) begin
      coef_mem[CIW'(in_coef_index)] <= in_coef_value;
    end
  end

  always_comb begin
    for (int a = 0; a < NC; a++) begin
      for (int b = 0; b < NC; b++) begin
        coef_sel[a][b] = '0;
        for (int rr = 0; rr <= MAXR; rr++) begin
          if (32'(r_eff) == rr && a <= 2 * rr && b <= 2 * rr) begin
            coef_sel[a][b] = coef_mem[CIW'((2 * rr - a) * MAX_KERNEL + (2 * rr - b))];
          end
        end
      end
    end
  end

  // Line buffer: each word holds the older rows of one column.
  always_ff @(posedge clk) begin
    byp_data_r <= wdata;
  end

  assign line_word = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    col_new[0] = {in_red, in_green, in_blue};
    for (int i = 1; i < NC; i++) begin
      col_new[i] = line_word[i-1];
    end
  end

  assign wdata = col_new[LR-1:0];

  rkc_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (adv),
    .waddr (col_r),
    .wdata (wdata),
    .raddr (col_nxt),
    .rdata (ram_rdata)
  );

  // Window edge masks for the result being started
  always_comb begin
    int xi;
    int yi;
    for (int a = 0; a < NC; a++) begin
      xi = int'(ox_r) + int'(r_eff) - a;
      yi = int'(oy_r) + int'(r_eff) - a;
      cmask_nxt[a] = (a <= 2 * int'(r_eff)) && xi >= 0 && xi < int'(w_eff);
      rmask_nxt[a] = (a <= 2 * int'(r_eff)) && yi >= 0 && yi < int'(h_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      cmask0_r <= cmask_nxt;
      rmask0_r <= rmask_nxt;
      fe0_r <= last;
    end
    if (en1) begin
      fe1_r <= fe0_r;
    end
    if (en2) begin
      fe2_r <= fe1_r;
    end
    if (en4) begin
      out_fe_r <= fe3_r;
      for (int ch = 0; ch < rkc_pkg::CH_N; ch++) begin
        out_rgb_r[ch] <= rnd_sat(tsum_r[ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en0) v0_r <= produce;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) out_valid_r <= v3_r;
    end
  end

  // Row of window cells, newest column in cell 0
  assign cen = '{shift: adv, prod: en1, csum: en2};
  assign col_chain[0] = col_new;

  for (genvar a = 0; a < NC; a++) begin : g_cell
    rkc_cell #(.NC(NC), .CSUM_W(CSUM_W)) u_cell (
      .clk     (clk),
      .en      (cen),
      .col_in  (col_chain[a]),
      .coef    (coef_sel[a]),
      .col_ok  (cmask0_r[a]),
      .row_ok  (rmask0_r),
      .col_out (col_chain[a+1]),
      .csum_r  (csum[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      fe3_r <= fe2_r;
      for (int ch = 0; ch < rkc_pkg::CH_N; ch++) begin
        logic signed [TS-1:0] s;
        s = '0;
        for (int a = 0; a < NC; a++) begin
          s = s + TS'($signed(csum[a][ch]));
        end
        tsum_r[ch] <= s;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_red = out_rgb_r[2];
  assign out_green = out_rgb_r[1];
  assign out_blue = out_rgb_r[0];
  assign out_frame_end = out_fe_r;

endmodule
